// ----- rtl/core/a64enc_pkg.sv -----
// ----------------------------------------------------------------------------
// a64enc_pkg
// shared types and opcode constants for the arm64 instruction encoder
// ----------------------------------------------------------------------------
package a64enc_pkg;

    typedef enum logic [3:0] {
        OP_MUL   = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_SDIV  = 4'd3,
        OP_MOD   = 4'd4,
        OP_LDP   = 4'd5,
        OP_STP   = 4'd6,
        OP_LDR   = 4'd7,
        OP_STR   = 4'd8,
        OP_MOV   = 4'd9,
        OP_CMP   = 4'd10,
        OP_BCOND = 4'd11,
        OP_B     = 4'd12,
        OP_BL    = 4'd13,
        OP_RET   = 4'd14
    } op_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_IMM = 2'd1,
        ST_OFS = 2'd2,
        ST_UNK = 2'd3
    } status_t;

    // request fields as carried on the input stream
    typedef struct packed {
        logic [3:0]         cond_code;
        logic signed [31:0] immediate;
        logic [4:0]         reg_m;
        logic [4:0]         reg_n;
        logic [4:0]         reg_d;
        logic               use_immediate;
        logic               half_width;
        logic [3:0]         req_type;
    } req_t;

    localparam int REQ_W = $bits(req_t);

    // encoder answer for one request: one or two words
    typedef struct packed {
        logic [31:0] word0;
        status_t     status;
        logic        two_words;
        logic [31:0] word1;
    } enc_result_t;

    // base opcodes, x form and w form
    localparam logic [31:0] MUL_X   = 32'h9B007C00;
    localparam logic [31:0] MUL_W   = 32'h1B007C00;
    localparam logic [31:0] ADDI_X  = 32'h91000000;
    localparam logic [31:0] ADDI_W  = 32'h11000000;
    localparam logic [31:0] SUBI_X  = 32'hD1000000;
    localparam logic [31:0] SUBI_W  = 32'h51000000;
    localparam logic [31:0] ADDR_X  = 32'h8B000000;
    localparam logic [31:0] ADDR_W  = 32'h0B000000;
    localparam logic [31:0] SUBR_X  = 32'hCB000000;
    localparam logic [31:0] SUBR_W  = 32'h4B000000;
    localparam logic [31:0] SDIV_X  = 32'h9AC00C00;
    localparam logic [31:0] SDIV_W  = 32'h1AC00C00;
    localparam logic [31:0] MSUB_X  = 32'h9B008000;
    localparam logic [31:0] MSUB_W  = 32'h1B008000;
    localparam logic [31:0] LDP_X   = 32'hA9400000;
    localparam logic [31:0] LDP_W   = 32'h29400000;
    localparam logic [31:0] STP_X   = 32'hA8800000;
    localparam logic [31:0] STP_W   = 32'h28800000;
    localparam logic [31:0] LDR_X   = 32'hF9400000;
    localparam logic [31:0] LDR_W   = 32'hB9400000;
    localparam logic [31:0] STR_X   = 32'hF9000000;
    localparam logic [31:0] STR_W   = 32'hB9000000;
    localparam logic [31:0] MOVZ_X  = 32'hD2800000;
    localparam logic [31:0] MOVZ_W  = 32'h52800000;
    localparam logic [31:0] ORR_X   = 32'hAA0003E0;
    localparam logic [31:0] ORR_W   = 32'h2A0003E0;
    localparam logic [31:0] CMPI_X  = 32'hF100001F;
    localparam logic [31:0] CMPI_W  = 32'h7100001F;
    localparam logic [31:0] CMPR_X  = 32'hEB00001F;
    localparam logic [31:0] CMPR_W  = 32'h6B00001F;
    localparam logic [31:0] BCOND   = 32'h54000000;
    localparam logic [31:0] B_OP    = 32'h14000000;
    localparam logic [31:0] BL_OP   = 32'h94000000;
    localparam logic [31:0] RET_OP  = 32'hD65F03C0;

    // scratch register for the quotient of a mod
    localparam logic [4:0]  REG_TMP = 5'd30;

    // offset limits
    localparam logic signed [31:0] PAIR_MIN  = -32'sd64;
    localparam logic signed [31:0] PAIR_MAX  = 32'sd63;
    localparam logic signed [31:0] LDST_MAX  = 32'sd4095;
    localparam logic signed [31:0] BCOND_MIN = -32'sh100000;
    localparam logic signed [31:0] BCOND_MAX = 32'sh0FFFFC;
    localparam logic signed [31:0] BR_MIN    = -32'sh2000000;
    localparam logic signed [31:0] BR_MAX    = 32'sh1FFFFFF;

endpackage

// ----- rtl/core/a64enc_encode.sv -----
// ----------------------------------------------------------------------------
// a64enc_encode
// combinational encoder: one request to one or two instruction words
// ----------------------------------------------------------------------------
module a64enc_encode
    import a64enc_pkg::*;
(
    input  req_t        req,
    output enc_result_t res
);

    logic        w32;
    logic [31:0] rd_f;
    logic [31:0] rn_f;
    logic [31:0] rm_f;
    logic [31:0] uimm;

    assign w32  = req.half_width;
    assign rd_f = 32'(req.reg_d);
    assign rn_f = 32'(req.reg_n) << 5;
    assign rm_f = 32'(req.reg_m) << 16;
    assign uimm = req.immediate;

    always_comb
    begin
        res.word0     = '0;
        res.status    = ST_OK;
        res.two_words = 1'b0;
        res.word1     = '0;
        unique case (op_t'(req.req_type))
            OP_MUL:
            begin
                if (req.use_immediate)
                    res.status = ST_IMM;
                else
                    res.word0 = (w32 ? MUL_W : MUL_X) | rd_f | rn_f | rm_f;
            end
            OP_ADD, OP_SUB:
            begin
                if (req.use_immediate)
                    res.word0 = ((req.req_type == OP_ADD) ? (w32 ? ADDI_W : ADDI_X)
                                                          : (w32 ? SUBI_W : SUBI_X))
                                | rd_f | rn_f | (32'(uimm[11:0]) << 10);
                else
                    res.word0 = ((req.req_type == OP_ADD) ? (w32 ? ADDR_W : ADDR_X)
                                                          : (w32 ? SUBR_W : SUBR_X))
                                | rd_f | rn_f | rm_f;
            end
            OP_SDIV:
            begin
                if (req.use_immediate)
                    res.status = ST_IMM;
                else
                    res.word0 = (w32 ? SDIV_W : SDIV_X) | rd_f | rn_f | rm_f;
            end
            OP_MOD:
            begin
                if (req.use_immediate)
                    res.status = ST_IMM;
                else
                begin
                    // sdiv x30, n, m then msub d, x30, m, n
                    res.two_words = 1'b1;
                    res.word0 = (w32 ? SDIV_W : SDIV_X) | 32'(REG_TMP) | rn_f | rm_f;
                    res.word1 = (w32 ? MSUB_W : MSUB_X) | rd_f | (32'(REG_TMP) << 5)
                                | rm_f | (32'(req.reg_n) << 10);
                end
            end
            OP_LDP, OP_STP:
            begin
                if (req.immediate < PAIR_MIN || req.immediate > PAIR_MAX
                    || uimm[2:0] != 3'd0)
                    res.status = ST_OFS;
                else
                    res.word0 = ((req.req_type == OP_LDP) ? (w32 ? LDP_W : LDP_X)
                                                          : (w32 ? STP_W : STP_X))
                                | (32'(uimm[9:3]) << 15) | (32'(req.reg_m) << 10)
                                | rn_f | rd_f;
            end
            OP_LDR, OP_STR:
            begin
                if (req.immediate < 32'sd0 || req.immediate > LDST_MAX)
                    res.status = ST_OFS;
                else
                    res.word0 = ((req.req_type == OP_LDR) ? (w32 ? LDR_W : LDR_X)
                                                          : (w32 ? STR_W : STR_X))
                                | (32'(uimm[13:2]) << 10) | rn_f | rd_f;
            end
            OP_MOV:
            begin
                if (req.use_immediate)
                    res.word0 = (w32 ? MOVZ_W : MOVZ_X) | rd_f | (32'(uimm[15:0]) << 5);
                else
                    res.word0 = (w32 ? ORR_W : ORR_X) | rd_f | rm_f;
            end
            OP_CMP:
            begin
                if (req.use_immediate)
                    res.word0 = (w32 ? CMPI_W : CMPI_X) | rn_f | (32'(uimm[11:0]) << 10);
                else
                    res.word0 = (w32 ? CMPR_W : CMPR_X) | rm_f | rn_f;
            end
            OP_BCOND:
            begin
                if (req.immediate < BCOND_MIN || req.immediate > BCOND_MAX)
                    res.status = ST_OFS;
                else
                    res.word0 = BCOND | (32'(uimm[20:2]) << 5) | 32'(req.cond_code);
            end
            OP_B, OP_BL:
            begin
                if (req.immediate < BR_MIN || req.immediate > BR_MAX)
                    res.status = ST_OFS;
                else
                    res.word0 = ((req.req_type == OP_B) ? B_OP : BL_OP) | 32'(uimm[27:2]);
            end
            OP_RET:
            begin
                res.word0 = RET_OP;
            end
            default:
            begin
                res.status = ST_UNK;
            end
        endcase
    end

endmodule

// ----- rtl/core/arm64_instruction_encoder_top.sv -----
// ----------------------------------------------------------------------------
// arm64_instruction_encoder_top
// stream wrapper: input register, encoder, result register with second-word hold
// ----------------------------------------------------------------------------
// path: an accepted request item passes through the input register, then the
//   result register, from which it leaves as a result item
// throughput: one request item per cycle while m_tready is high; a register mod
//   holds up the input, as its msub word waits in a hold register behind the sdiv word
// reset: rst_n clears all valid flags, hold included; payload registers are not reset
// ----------------------------------------------------------------------------
module arm64_instruction_encoder_top
    import a64enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // request stream
    // s_tdata fields, lowest bit up: req_type[3:0], half_width[4], use_immediate[5],
    //   reg_d[10:6], reg_n[15:11], reg_m[20:16], immediate[52:21], cond_code[56:53],
    //   zero fill[63:57]
    input  logic [63:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,

    // result stream
    // m_tdata fields, lowest bit up: inst_word[31:0], status[33:32], zero fill[39:34]
    output logic [39:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // last word of the request
    output logic        m_tlast
);

    // input register stage
    logic        in_valid_reg;
    req_t        in_req_reg;

    // result register stage
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_word_reg;
    logic [31:0] out_word_next;
    status_t     out_status_reg;
    status_t     out_status_next;
    logic        out_last_reg;
    logic        out_last_next;

    // hold for the second word of a mod
    logic        pend_valid_reg;
    logic        pend_valid_next;
    logic [31:0] pend_word_reg;
    logic [31:0] pend_word_next;

    enc_result_t enc;
    logic        load_ok;
    logic        advance;
    logic        s_fire;

    a64enc_encode u_encode
    (
        .req (in_req_reg),
        .res (enc)
    );

    // result register can take a new item when empty, or when its item
    // leaves this cycle and no second word is waiting
    assign load_ok  = !out_valid_reg || (m_tready && !pend_valid_reg);
    assign advance  = in_valid_reg && load_ok;
    assign s_tready = !in_valid_reg || load_ok;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_word_next  = pend_word_reg;
        if (out_valid_reg && m_tready && pend_valid_reg)
        begin
            // msub word moves up behind the sdiv word
            out_word_next   = pend_word_reg;
            out_status_next = ST_OK;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
        else if (advance)
        begin
            out_valid_next  = 1'b1;
            out_word_next   = enc.word0;
            out_status_next = enc.status;
            out_last_next   = !enc.two_words;
            pend_valid_next = enc.two_words;
            pend_word_next  = enc.word1;
        end
        else if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_fire)
            in_req_reg <= req_t'(s_tdata[REQ_W-1:0]);
        out_word_reg   <= out_word_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        pend_word_reg  <= pend_word_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_status_reg, out_word_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- test/tb_arm64_instruction_encoder_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arm64_instruction_encoder_top
// stream-level check of the arm64 instruction encoder: every request item is
// encoded again by a scoreboard class, and each result item is compared in
// order with the oldest predicted word, under random sender gaps and
// receiver stalls
// ----------------------------------------------------------------------------
module tb_arm64_instruction_encoder_top
    import a64enc_pkg::*;
;

    localparam int          CLK_HALF     = 10;
    localparam int          RESET_CYCLES = 10;
    localparam int          RANDOM_REQS  = 900;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          MAX_REPORTS  = 10;

    // request code outside the operation set
    localparam logic [3:0]  OP_UNKNOWN   = 4'd15;
    // scratch register that holds the quotient of a mod
    localparam logic [31:0] REG_QUOT     = 32'd30;
    // zero register encoding, used as rd of cmp and rn of register mov
    localparam logic [31:0] REG_ZR       = 32'd31;

    // branch offset windows in bytes
    localparam int          BCOND_LO     = -1048576;
    localparam int          BCOND_HI     = 1048572;
    localparam int          BR_LO        = -33554432;
    localparam int          BR_HI        = 33554431;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  status;
        logic        is_last;
    } enc_word_t;

    // ------------------------------------------------------------------------
    // encoding scoreboard
    // ------------------------------------------------------------------------
    class enc_scoreboard;
        enc_word_t expected_words[$];
        int        mismatches;
        int        requests;
        int        words_checked;
        int        mods_seen;
        int        error_words;

        function new();
            mismatches    = 0;
            requests      = 0;
            words_checked = 0;
            mods_seen     = 0;
            error_words   = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // work out the word(s) one accepted request must produce
        function void note_request(req_t r);
            logic [31:0]        u;
            logic signed [31:0] s;
            logic [31:0]        rd;
            logic [31:0]        rn;
            logic [31:0]        rm;
            logic [31:0]        w;
            logic [1:0]         st;
            logic               w32;
            logic               useimm;

            u      = r.immediate;
            s      = r.immediate;
            rd     = 32'(r.reg_d);
            rn     = 32'(r.reg_n);
            rm     = 32'(r.reg_m);
            w32    = r.half_width;
            useimm = r.use_immediate;
            w      = 32'd0;
            st     = ST_OK;
            requests++;

            case (r.req_type)
                OP_MUL:
                    if (useimm)
                        st = ST_IMM;
                    else
                        w = (w32 ? 32'h1B007C00 : 32'h9B007C00) | rd | (rn << 5) | (rm << 16);
                OP_ADD, OP_SUB:
                    if (useimm)
                    begin
                        if (r.req_type == OP_ADD)
                            w = w32 ? 32'h11000000 : 32'h91000000;
                        else
                            w = w32 ? 32'h51000000 : 32'hD1000000;
                        w = w | rd | (rn << 5) | ({20'd0, u[11:0]} << 10);
                    end
                    else
                    begin
                        if (r.req_type == OP_ADD)
                            w = w32 ? 32'h0B000000 : 32'h8B000000;
                        else
                            w = w32 ? 32'h4B000000 : 32'hCB000000;
                        w = w | rd | (rn << 5) | (rm << 16);
                    end
                OP_SDIV:
                    if (useimm)
                        st = ST_IMM;
                    else
                        w = (w32 ? 32'h1AC00C00 : 32'h9AC00C00) | rd | (rn << 5) | (rm << 16);
                OP_MOD:
                    if (useimm)
                        st = ST_IMM;
                    else
                    begin
                        // sdiv into the scratch register, then msub for the remainder
                        mods_seen++;
                        w = (w32 ? 32'h1AC00C00 : 32'h9AC00C00) | REG_QUOT | (rn << 5)
                            | (rm << 16);
                        expected_words.push_back('{w, ST_OK, 1'b0});
                        w = (w32 ? 32'h1B008000 : 32'h9B008000) | rd | (REG_QUOT << 5)
                            | (rm << 16) | (rn << 10);
                    end
                OP_LDP, OP_STP:
                    if (s < -64 || s > 63 || u[2:0] != 3'd0)
                        st = ST_OFS;
                    else
                    begin
                        if (r.req_type == OP_LDP)
                            w = w32 ? 32'h29400000 : 32'hA9400000;
                        else
                            w = w32 ? 32'h28800000 : 32'hA8800000;
                        w = w | ({25'd0, u[9:3]} << 15) | (rm << 10) | (rn << 5) | rd;
                    end
                OP_LDR, OP_STR:
                    if (s < 0 || s > 4095)
                        st = ST_OFS;
                    else
                    begin
                        if (r.req_type == OP_LDR)
                            w = w32 ? 32'hB9400000 : 32'hF9400000;
                        else
                            w = w32 ? 32'hB9000000 : 32'hF9000000;
                        w = w | ({20'd0, u[13:2]} << 10) | (rn << 5) | rd;
                    end
                OP_MOV:
                    if (useimm)
                        w = (w32 ? 32'h52800000 : 32'hD2800000) | rd | ({16'd0, u[15:0]} << 5);
                    else
                        w = (w32 ? 32'h2A000000 : 32'hAA000000) | (REG_ZR << 5) | rd
                            | (rm << 16);
                OP_CMP:
                    if (useimm)
                        w = (w32 ? 32'h71000000 : 32'hF1000000) | REG_ZR | (rn << 5)
                            | ({20'd0, u[11:0]} << 10);
                    else
                        w = (w32 ? 32'h6B000000 : 32'hEB000000) | REG_ZR | (rm << 16)
                            | (rn << 5);
                OP_BCOND:
                    if (s < BCOND_LO || s > BCOND_HI)
                        st = ST_OFS;
                    else
                        w = 32'h54000000 | ({13'd0, u[20:2]} << 5) | {28'd0, r.cond_code};
                OP_B, OP_BL:
                    if (s < BR_LO || s > BR_HI)
                        st = ST_OFS;
                    else
                        w = (r.req_type == OP_B ? 32'h14000000 : 32'h94000000)
                            | {6'd0, u[27:2]};
                OP_RET:
                    w = 32'hD65F03C0;
                default:
                    st = ST_UNK;
            endcase

            if (st != ST_OK)
                error_words++;
            expected_words.push_back('{w, st, 1'b1});
        endfunction

        // compare one result item with the oldest prediction
        function void check_word(logic [39:0] data, logic lst);
            enc_word_t want;

            words_checked++;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result item: word %h status %0d last %0d",
                             data[31:0], data[33:32], lst);
                return;
            end
            want = expected_words.pop_front();
            if (data[31:0] !== want.word || data[33:32] !== want.status
                || lst !== want.is_last)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("mismatch on result item %0d: expected word %h status %0d last %0d",
                             words_checked, want.word, want.status, want.is_last);
                    $display("    got word %h status %0d last %0d",
                             data[31:0], data[33:32], lst);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic [63:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        m_tlast;

    enc_scoreboard sb;
    int            cycle_count;

    arm64_instruction_encoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // cycle limit and receiver stall pattern; the pattern moves through
    // always ready, coin flip, mostly ready and a fixed one-in-three stall
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            case ((cycle_count / 97) % 4)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                2:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ((cycle_count % 3) != 0);
            endcase
        end
    end

    // handshake monitor, sampled at the edge that completes each handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata[REQ_W-1:0]);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata, m_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic req_t make_req(logic [3:0] op, logic w32, logic useimm,
                                      logic [4:0] rd, logic [4:0] rn, logic [4:0] rm,
                                      logic [31:0] imm, logic [3:0] cond);
        req_t r;

        r.req_type      = op;
        r.half_width    = w32;
        r.use_immediate = useimm;
        r.reg_d         = rd;
        r.reg_n         = rn;
        r.reg_m         = rm;
        r.immediate     = imm;
        r.cond_code     = cond;
        return r;
    endfunction

    // offsets on and just past the edges of every range check
    function automatic logic [31:0] pick_boundary();
        case ($urandom_range(0, 17))
            0:       return -32'sd64;
            1:       return -32'sd65;
            2:       return 32'sd63;
            3:       return 32'sd56;
            4:       return 32'sd64;
            5:       return -32'sd1;
            6:       return 32'sd0;
            7:       return 32'sd4095;
            8:       return 32'sd4096;
            9:       return BCOND_LO;
            10:      return BCOND_LO - 1;
            11:      return BCOND_HI;
            12:      return BCOND_HI + 1;
            13:      return BR_LO;
            14:      return BR_LO - 1;
            15:      return BR_HI;
            16:      return BR_HI + 1;
            default: return 32'h80000000;
        endcase
    endfunction

    // mostly in-range offsets for the operation, some edges, some raw noise
    function automatic logic [31:0] rand_offset(logic [3:0] op);
        int unsigned k;

        k = $urandom_range(0, 9);
        if (k < 2)
            return $urandom;
        if (k == 2)
            return pick_boundary();
        case (op)
            OP_LDP, OP_STP: return ($urandom_range(0, 15) - 8) * 8;
            OP_LDR, OP_STR: return $urandom_range(0, 4095);
            OP_BCOND:       return $urandom_range(0, 32'h1FFFFC) - 32'h100000;
            OP_B, OP_BL:    return $urandom_range(0, 32'h3FFFFFF) - 32'h2000000;
            default:        return $urandom;
        endcase
    endfunction

    function automatic req_t rand_request();
        req_t r;

        if ($urandom_range(0, 99) < 3)
            r.req_type = OP_UNKNOWN;
        else
            r.req_type = 4'($urandom_range(0, 14));
        r.half_width = 1'($urandom_range(0, 1));
        // keep mul, sdiv and mod mostly in register form so they encode
        if (r.req_type == OP_MUL || r.req_type == OP_SDIV || r.req_type == OP_MOD)
            r.use_immediate = ($urandom_range(0, 4) == 0);
        else
            r.use_immediate = 1'($urandom_range(0, 1));
        r.reg_d     = 5'($urandom_range(0, 31));
        r.reg_n     = 5'($urandom_range(0, 31));
        r.reg_m     = 5'($urandom_range(0, 31));
        r.immediate = rand_offset(r.req_type);
        r.cond_code = 4'($urandom_range(0, 15));
        return r;
    endfunction

    // present one request item and hold it until the handshake completes
    task automatic send_request(input req_t r);
        s_tdata  <= {{(64 - REQ_W){1'b0}}, r};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int burst_left;
        int gap;

        sb          = new();
        cycle_count = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 64'd0;
        m_tready    = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every operation, both widths, field extremes, error cases
        send_request(make_req(OP_MUL,   1'b0, 1'b0, 5'd31, 5'd0,  5'd31, 32'd0, 4'd0));
        send_request(make_req(OP_MUL,   1'b1, 1'b1, 5'd1,  5'd2,  5'd3,  32'd5, 4'd0));
        send_request(make_req(OP_ADD,   1'b0, 1'b1, 5'd0,  5'd31, 5'd0,  32'hFFFFFFFF, 4'd0));
        send_request(make_req(OP_ADD,   1'b1, 1'b0, 5'd31, 5'd31, 5'd31, 32'd0, 4'd15));
        send_request(make_req(OP_SUB,   1'b1, 1'b1, 5'd4,  5'd5,  5'd6,  32'h7FFFFFFF, 4'd0));
        send_request(make_req(OP_SUB,   1'b0, 1'b0, 5'd7,  5'd8,  5'd9,  32'h80000000, 4'd0));
        send_request(make_req(OP_SDIV,  1'b1, 1'b0, 5'd10, 5'd11, 5'd12, 32'd0, 4'd0));
        send_request(make_req(OP_SDIV,  1'b0, 1'b1, 5'd10, 5'd11, 5'd12, 32'd3, 4'd0));
        send_request(make_req(OP_MOD,   1'b0, 1'b0, 5'd5,  5'd31, 5'd0,  32'd0, 4'd0));
        send_request(make_req(OP_MOD,   1'b1, 1'b0, 5'd31, 5'd0,  5'd31, 32'd0, 4'd0));
        send_request(make_req(OP_MOD,   1'b0, 1'b1, 5'd1,  5'd2,  5'd3,  32'd7, 4'd0));
        send_request(make_req(OP_LDP,   1'b0, 1'b0, 5'd29, 5'd31, 5'd30, -32'sd64, 4'd0));
        send_request(make_req(OP_LDP,   1'b1, 1'b0, 5'd0,  5'd1,  5'd2,  32'd56, 4'd0));
        send_request(make_req(OP_STP,   1'b0, 1'b0, 5'd0,  5'd1,  5'd2,  32'd63, 4'd0));
        send_request(make_req(OP_STP,   1'b1, 1'b0, 5'd0,  5'd1,  5'd2,  -32'sd72, 4'd0));
        send_request(make_req(OP_LDR,   1'b0, 1'b0, 5'd3,  5'd31, 5'd0,  32'd4095, 4'd0));
        send_request(make_req(OP_LDR,   1'b1, 1'b0, 5'd3,  5'd4,  5'd0,  -32'sd1, 4'd0));
        send_request(make_req(OP_STR,   1'b1, 1'b0, 5'd3,  5'd4,  5'd0,  32'd4096, 4'd0));
        send_request(make_req(OP_MOV,   1'b0, 1'b1, 5'd9,  5'd0,  5'd0,  32'hFFFF1234, 4'd0));
        send_request(make_req(OP_MOV,   1'b1, 1'b0, 5'd9,  5'd0,  5'd31, 32'd0, 4'd0));
        send_request(make_req(OP_CMP,   1'b0, 1'b1, 5'd0,  5'd17, 5'd0,  32'h00000ABC, 4'd0));
        send_request(make_req(OP_CMP,   1'b1, 1'b0, 5'd0,  5'd31, 5'd31, 32'd0, 4'd0));
        send_request(make_req(OP_BCOND, 1'b0, 1'b0, 5'd0,  5'd0,  5'd0,  BCOND_LO, 4'd15));
        send_request(make_req(OP_BCOND, 1'b0, 1'b0, 5'd0,  5'd0,  5'd0,  BCOND_HI, 4'd0));
        send_request(make_req(OP_BCOND, 1'b0, 1'b0, 5'd0,  5'd0,  5'd0,  32'h00100000, 4'd1));
        send_request(make_req(OP_B,     1'b0, 1'b0, 5'd0,  5'd0,  5'd0,  BR_HI, 4'd0));
        send_request(make_req(OP_BL,    1'b0, 1'b0, 5'd0,  5'd0,  5'd0,  BR_LO, 4'd0));
        send_request(make_req(OP_BL,    1'b1, 1'b1, 5'd0,  5'd0,  5'd0,  BR_LO - 1, 4'd0));
        send_request(make_req(OP_RET,   1'b1, 1'b1, 5'd31, 5'd31, 5'd31, 32'hFFFFFFFF, 4'd15));
        send_request(make_req(OP_UNKNOWN, 1'b0, 1'b1, 5'd1, 5'd2, 5'd3, 32'd8, 4'd4));

        // random requests in bursts with idle gaps between them
        burst_left = 0;
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12)
                                                  : $urandom_range(0, 3);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            send_request(rand_request());
            burst_left--;
        end
        s_tvalid <= 1'b0;

        // wait until the monitor has noted the last request, then drain
        // what is still in flight and let the pipeline settle
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("encoded %0d requests into %0d result items (%0d register mods)",
                 sb.requests, sb.words_checked, sb.mods_seen);
        $display("%0d error results seen, %0d mismatches", sb.error_words, sb.mismatches);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/a64enc_pkg.sv
rtl/core/a64enc_encode.sv
rtl/core/arm64_instruction_encoder_top.sv
test/tb_arm64_instruction_encoder_top.sv
